[hdl/gaa_pkg.sv]
// ----------------------------------------------------------------------------
// gaa_pkg
// Types and constants shared by the gamepad action auto-repeat block.
// ----------------------------------------------------------------------------
package gaa_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_DOWN   = 2'd1,
    KIND_UP     = 2'd2,
    KIND_AXIS   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        controller_id;
    logic [4:0]         button_code;
    logic [2:0]         axis_id;
    logic signed [15:0] axis_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] action_code;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [14:0]        axis_deadzone;
    logic [15:0]        initial_delay_ms;
    logic [15:0]        repeat_interval_ms;
    logic signed [16:0] active_controller_id;
  } cfg_t;

  // Register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd3;
  localparam int unsigned CFG_DATA_W = 17;

  // Reset values of the registers
  localparam logic [14:0]        RST_DEADZONE = 15'd16000;
  localparam logic [15:0]        RST_INITIAL  = 16'd500;
  localparam logic [15:0]        RST_INTERVAL = 16'd180;
  localparam logic signed [16:0] RST_ACTIVE   = -17'sd1;

  // Button codes
  localparam logic [4:0] BTN_A      = 5'd0;
  localparam logic [4:0] BTN_B      = 5'd1;
  localparam logic [4:0] BTN_X      = 5'd2;
  localparam logic [4:0] BTN_Y      = 5'd3;
  localparam logic [4:0] BTN_BACK   = 5'd4;
  localparam logic [4:0] BTN_START  = 5'd6;
  localparam logic [4:0] BTN_LSHLD  = 5'd9;
  localparam logic [4:0] BTN_RSHLD  = 5'd10;
  localparam logic [4:0] BTN_DUP    = 5'd11;
  localparam logic [4:0] BTN_DDOWN  = 5'd12;
  localparam logic [4:0] BTN_DLEFT  = 5'd13;
  localparam logic [4:0] BTN_DRIGHT = 5'd14;

  // Axis ids
  localparam logic [2:0] AXIS_LX = 3'd0;
  localparam logic [2:0] AXIS_LY = 3'd1;

  // Action codes; one bit each in the pending action mask
  localparam int unsigned NUM_ACTIONS  = 12;
  localparam int unsigned ACT_ACCEPT   = 0;
  localparam int unsigned ACT_CANCEL   = 1;
  localparam int unsigned ACT_X        = 2;
  localparam int unsigned ACT_Y        = 3;
  localparam int unsigned ACT_QUIT     = 4;
  localparam int unsigned ACT_PLAY     = 5;
  localparam int unsigned ACT_LSHLD    = 6;
  localparam int unsigned ACT_RSHLD    = 7;
  localparam int unsigned ACT_DIR_BASE = 8;

  // Directions, in service order
  localparam int unsigned NUM_DIRS  = 4;
  localparam int unsigned DIR_UP    = 0;
  localparam int unsigned DIR_DOWN  = 1;
  localparam int unsigned DIR_LEFT  = 2;
  localparam int unsigned DIR_RIGHT = 3;

  typedef logic [NUM_ACTIONS-1:0] act_mask_t;

endpackage

[hdl/gaa_step.sv]
// ----------------------------------------------------------------------------
// gaa_step
// Next direction state and pending action mask for one item.
// ----------------------------------------------------------------------------
module gaa_step
  import gaa_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  in_item_t              item,
  input  cfg_t                  cfg,
  input  logic [NUM_DIRS-1:0]   held,
  input  logic [TIMER_BITS-1:0] cd      [NUM_DIRS],
  output logic [NUM_DIRS-1:0]   held_nxt,
  output logic [TIMER_BITS-1:0] cd_nxt  [NUM_DIRS],
  output act_mask_t             mask
);

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  logic [TIMER_BITS-1:0] load_init;
  logic [TIMER_BITS-1:0] load_int;
  logic [TIMER_BITS-1:0] dec [NUM_DIRS];
  logic [NUM_DIRS-1:0]   touch;
  logic [NUM_DIRS-1:0]   want;
  logic                  active;
  logic signed [16:0]    val;
  logic signed [16:0]    dz;
  logic                  neg;
  logic                  pos;

  // Saturate the delays to what the timer can hold
  assign load_init = (33'(cfg.initial_delay_ms) > TMAX) ? TIMER_BITS'(TMAX)
                                                        : TIMER_BITS'(cfg.initial_delay_ms);
  assign load_int  = (33'(cfg.repeat_interval_ms) > TMAX) ? TIMER_BITS'(TMAX)
                                                          : TIMER_BITS'(cfg.repeat_interval_ms);

  // A negative active id has bit 16 set and never matches
  assign active = ({1'b0, item.controller_id} == $unsigned(cfg.active_controller_id));

  assign val = $signed({item.axis_value[15], item.axis_value});
  assign dz  = $signed({2'b00, cfg.axis_deadzone});
  assign neg = (val < -dz);
  assign pos = (val > dz);

  always_comb begin
    held_nxt = held;
    cd_nxt   = cd;
    mask     = '0;
    touch    = '0;
    want     = '0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      dec[d] = (cd[d] != '0) ? cd[d] - TIMER_BITS'(1) : cd[d];
    end

    unique case (item.kind)
      KIND_TICK: begin
        for (int d = 0; d < NUM_DIRS; d++) begin
          if (held[d]) begin
            if (dec[d] == '0) begin
              mask[ACT_DIR_BASE + d] = 1'b1;
              cd_nxt[d]              = load_int;
            end else begin
              cd_nxt[d] = dec[d];
            end
          end
        end
      end
      KIND_DOWN: begin
        if (active) begin
          unique case (item.button_code)
            BTN_A:      mask[ACT_ACCEPT] = 1'b1;
            BTN_B:      mask[ACT_CANCEL] = 1'b1;
            BTN_X:      mask[ACT_X]      = 1'b1;
            BTN_Y:      mask[ACT_Y]      = 1'b1;
            BTN_BACK:   mask[ACT_QUIT]   = 1'b1;
            BTN_START:  mask[ACT_PLAY]   = 1'b1;
            BTN_LSHLD:  mask[ACT_LSHLD]  = 1'b1;
            BTN_RSHLD:  mask[ACT_RSHLD]  = 1'b1;
            BTN_DUP:    begin touch[DIR_UP]    = 1'b1; want[DIR_UP]    = 1'b1; end
            BTN_DDOWN:  begin touch[DIR_DOWN]  = 1'b1; want[DIR_DOWN]  = 1'b1; end
            BTN_DLEFT:  begin touch[DIR_LEFT]  = 1'b1; want[DIR_LEFT]  = 1'b1; end
            BTN_DRIGHT: begin touch[DIR_RIGHT] = 1'b1; want[DIR_RIGHT] = 1'b1; end
            default: ;
          endcase
        end
      end
      KIND_UP: begin
        // release is not filtered by controller
        unique case (item.button_code)
          BTN_DUP:    touch[DIR_UP]    = 1'b1;
          BTN_DDOWN:  touch[DIR_DOWN]  = 1'b1;
          BTN_DLEFT:  touch[DIR_LEFT]  = 1'b1;
          BTN_DRIGHT: touch[DIR_RIGHT] = 1'b1;
          default: ;
        endcase
      end
      KIND_AXIS: begin
        if (active) begin
          unique case (item.axis_id)
            AXIS_LX: begin
              touch[DIR_LEFT]  = 1'b1;
              touch[DIR_RIGHT] = 1'b1;
              want[DIR_LEFT]   = neg;
              want[DIR_RIGHT]  = pos;
            end
            AXIS_LY: begin
              touch[DIR_UP]   = 1'b1;
              touch[DIR_DOWN] = 1'b1;
              want[DIR_UP]    = neg;
              want[DIR_DOWN]  = pos;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // Apply press and release; a change to the same state does nothing
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (touch[d] && (held[d] != want[d])) begin
        held_nxt[d] = want[d];
        if (want[d]) begin
          cd_nxt[d]              = load_init;
          mask[ACT_DIR_BASE + d] = 1'b1;
        end else begin
          cd_nxt[d] = '0;
        end
      end
    end
  end

endmodule

[hdl/gamepad_action_autorepeat.sv]
// ----------------------------------------------------------------------------
// gamepad_action_autorepeat
// Gamepad event to action code mapper with typematic direction repeat.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one event item per handshake (tick, button down/up, axis motion).
//            An item is taken when in_valid is high and in_stall is low.
//   out_*  : action items, zero to four per event item, in order; the last
//            one caused by an event carries last_of_run.
//   cfg_*  : register writes, always ready; write only while the block is idle.
// Flow: an event item waits in the input register until the previous run has
//   drained, is resolved in one pass; its actions are registered for out_*.
// Throughput: with out_stall low, one event item per cycle while it produces
//   at most one action; an item with more actions holds the output register
//   until all are taken, so the action output (one per cycle) sets the rate.
// Reset (synchronous, rst_n low): registers take their default values, all
//   directions are released, both holding registers empty.
// Receiver stall: the current action holds on out_data; one further event
//   item is taken into the input register, then in_stall rises.
// ----------------------------------------------------------------------------
module gamepad_action_autorepeat
  import gaa_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  cfg_t                  cfg_r;

  // Input register
  logic                  in_full_r;
  in_item_t              in_item_r;

  // Direction state
  logic [NUM_DIRS-1:0]   held_r;
  logic [NUM_DIRS-1:0]   held_nxt;
  logic [TIMER_BITS-1:0] cd_r   [NUM_DIRS];
  logic [TIMER_BITS-1:0] cd_nxt [NUM_DIRS];

  // Pending actions, emitted lowest code first
  act_mask_t             mask_r;
  act_mask_t             mask_nxt;
  act_mask_t             step_mask;

  logic                  in_acc;
  logic                  out_acc;
  logic                  single;
  logic                  drain_done;
  logic                  advance;
  logic [3:0]            low_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_deadzone        <= RST_DEADZONE;
      cfg_r.initial_delay_ms     <= RST_INITIAL;
      cfg_r.repeat_interval_ms   <= RST_INTERVAL;
      cfg_r.active_controller_id <= RST_ACTIVE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEADZONE: cfg_r.axis_deadzone        <= cfg_data[14:0];
        CFG_INITIAL:  cfg_r.initial_delay_ms     <= cfg_data[15:0];
        CFG_INTERVAL: cfg_r.repeat_interval_ms   <= cfg_data[15:0];
        CFG_ACTIVE:   cfg_r.active_controller_id <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Output side: the head of the mask is the current action
  assign single     = (mask_r != '0) && ((mask_r & (mask_r - act_mask_t'(1))) == '0);
  assign out_valid  = (mask_r != '0);
  assign out_acc    = out_valid && !out_stall;
  assign drain_done = (mask_r == '0) || (single && out_acc);

  // Advance the held item into the mask once the previous run is out
  assign advance  = in_full_r && drain_done;
  assign in_stall = in_full_r && !drain_done;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    low_code = '0;
    for (int i = NUM_ACTIONS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_code = 4'(i);
      end
    end
  end

  assign out_data.action_code = low_code;
  assign out_data.last_of_run = single;

  gaa_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .item     (in_item_r),
    .cfg      (cfg_r),
    .held     (held_r),
    .cd       (cd_r),
    .held_nxt (held_nxt),
    .cd_nxt   (cd_nxt),
    .mask     (step_mask)
  );

  always_comb begin
    if (advance) begin
      mask_nxt = step_mask;
    end else if (out_acc) begin
      // drop the action just taken
      mask_nxt = mask_r & (mask_r - act_mask_t'(1));
    end else begin
      mask_nxt = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      mask_r    <= '0;
      held_r    <= '0;
      for (int d = 0; d < NUM_DIRS; d++) begin
        cd_r[d] <= '0;
      end
    end else begin
      mask_r <= mask_nxt;
      if (in_acc) begin
        in_full_r <= 1'b1;
      end else if (advance) begin
        in_full_r <= 1'b0;
      end
      if (advance) begin
        held_r <= held_nxt;
        cd_r   <= cd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
  end

endmodule

[hdl/gaa_checker.sv]
// ----------------------------------------------------------------------------
// gaa_checker
// Port-level checks for the gamepad action auto-repeat block.
// ----------------------------------------------------------------------------
module gaa_checker
  import gaa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input out_item_t out_data,
  input logic      out_valid,
  input logic      out_stall
);

  // Stalled action holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled action changed");

  // A run continues until its last action
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_run |=> out_valid)
    else $error("run ended without last_of_run");

  // Only defined action codes leave the block
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.action_code <= 4'd11)
    else $error("action code out of range");

  // Reset empties both holding registers
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind gamepad_action_autorepeat gaa_checker u_gaa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
